FILE: src/rms_level_meter_db_assert.svh
// assertion macros for the rms level meter
// no dependencies; included by the top level
`ifndef RMS_LEVEL_METER_DB_ASSERT_SVH
`define RMS_LEVEL_METER_DB_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RLM_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("rlm assertion failed");
`define RLM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rlm assertion failed");
`else
`define RLM_ASSERT(label, clk, rst, prop)
`define RLM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: src/rlm_pkg.sv
// shared constants and types for the rms level meter
// no dependencies; used by every module of the block
package rlm_pkg;

  localparam int MAX_CHUNK   = 1024;
  localparam int FRAME_W     = 32;
  localparam int SHIFT_W     = 5;
  localparam int SAMPLE_W    = 16;
  localparam int SQUARE_W    = 31;
  localparam int COUNT_W     = $clog2(MAX_CHUNK + 1);
  localparam int SUM_W       = SQUARE_W + $clog2(MAX_CHUNK);
  localparam int CNT_W       = $clog2(SUM_W);
  localparam int MEAN_W      = 31;
  localparam int PROD_W      = 2 * MEAN_W;
  localparam int EXP_W       = 5;
  localparam int FRAC_W      = 24;
  localparam int L2_W        = EXP_W + FRAC_W;
  localparam int K_W         = 25;
  localparam int SCALE_SHIFT = 40;
  localparam int MAG_W       = 14;
  localparam int LEVEL_W     = 15;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET  = SHIFT_W'(14);
  localparam logic [EXP_W-1:0]   E_MAX        = EXP_W'(MEAN_W - 1);
  localparam logic [L2_W-1:0]    LOG_SPAN     = {E_MAX, {FRAC_W{1'b0}}};
  localparam logic [K_W-1:0]     K_Q16        = K_W'(19728302);
  localparam logic [MEAN_W-1:0]  MEAN_MAX     = MEAN_W'(1) << (MEAN_W - 1);
  localparam logic signed [LEVEL_W-1:0] SILENT_LEVEL = LEVEL_W'(-9600);

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic [SQUARE_W-1:0] square;
    logic                last;
  } q_entry_t;

  typedef struct packed {
    logic               start;
    logic [SUM_W-1:0]   dividend;
    logic [COUNT_W-1:0] divisor;
  } dl_req_t;

  typedef struct packed {
    logic                      busy;
    logic                      done;
    logic signed [LEVEL_W-1:0] level;
  } dl_rsp_t;

endpackage

FILE: src/rms_level_meter_db.sv
// top level of the rms level meter in hundredths of dbfs
// depends on rlm_pkg, rlm_front, rlm_queue, rlm_divlog, rlm_back, assertion header
//
// channel   dir  handshake          payload
// s_*       in   tvalid/tready      tdata: raw_frame[31:0]; tlast: chunk_last
// m_*       out  tvalid/tready      tdata: sample_out[15:0], level_centi_db[30:16];
//                                   tlast: level_valid; tuser: chunk_overflow
// cfg_*     in   cfg_valid/ready    cfg_data: sample_shift[4:0]
//
// one result transaction per input transaction, in order
// items that do not close a chunk stream at one per cycle while the output is not stalled
// a closing item holds the back end while the level unit divides, checks for a zero mean,
//   normalizes, runs 24 squarings and scales, and while the level is handed back and
//   emitted; a zero mean skips normalize, squaring and scale
// the queue lets the front keep taking items while the back end computes a level
// reset is synchronous on rst; shift returns to 14, level to -96.00 dB

`include "rms_level_meter_db_assert.svh"

module rms_level_meter_db (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // raw_frame[31:0]
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // sample_out[15:0], level_centi_db[30:16], zero[31]
  output logic        m_tlast,
  output logic        m_tuser,   // chunk_overflow[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);
  import rlm_pkg::*;

  // front to queue
  logic     fq_valid;
  logic     fq_ready;
  q_entry_t fq_data;
  // queue to back end
  logic     qb_valid;
  logic     qb_ready;
  q_entry_t qb_data;
  // back end to level unit
  dl_req_t  dl_req;
  dl_rsp_t  dl_rsp;

  // shift, wrap and square one frame per cycle while the queue has room
  rlm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_valid   (fq_valid),
    .q_ready   (fq_ready),
    .q_data    (fq_data)
  );

  // decouples the front from stalls in the back end
  rlm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_data  (qb_data)
  );

  // mean of squares and the log level, once per chunk
  rlm_divlog u_divlog (
    .clk (clk),
    .rst (rst),
    .req (dl_req),
    .rsp (dl_rsp)
  );

  // accumulation, level hold and output register
  rlm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (qb_valid),
    .q_ready  (qb_ready),
    .q_data   (qb_data),
    .dl_req   (dl_req),
    .dl_rsp   (dl_rsp),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // reported level always lies between -96.00 dB and full scale
  `RLM_ASSERT(a_level_range, clk, rst,
    !m_tvalid || ($signed(m_tdata[30:16]) <= 0 && $signed(m_tdata[30:16]) >= -9600))
  // a chunk never closes while the previous level is still being computed
  `RLM_ASSERT(a_start_idle, clk, rst, !dl_req.start || !dl_rsp.busy)
  // a closing item always sets the level unit running
  `RLM_ASSERT_NEXT(a_start_taken, clk, rst, dl_req.start, dl_rsp.busy)

endmodule

FILE: src/rlm_front.sv
// front end: sample shift register, shift and wrap, square for the queue
// depends on rlm_pkg
module rlm_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [rlm_pkg::FRAME_W-1:0]   s_tdata,
  input  logic                          s_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rlm_pkg::SHIFT_W-1:0]   cfg_data,
  output logic                          q_valid,
  input  logic                          q_ready,
  output rlm_pkg::q_entry_t             q_data
);
  import rlm_pkg::*;

  logic [SHIFT_W-1:0]         sample_shift;
  logic                       smp_valid;
  logic signed [SAMPLE_W-1:0] smp;
  logic                       smp_last;
  logic signed [FRAME_W-1:0]  shifted;
  logic signed [2*SAMPLE_W-1:0] sq_full;

  assign cfg_ready = 1'b1;
  assign s_tready  = !smp_valid || q_ready;
  assign shifted   = $signed(s_tdata) >>> sample_shift;
  assign sq_full   = (2*SAMPLE_W)'(smp) * (2*SAMPLE_W)'(smp);

  assign q_valid       = smp_valid;
  assign q_data.sample = smp;
  assign q_data.square = sq_full[SQUARE_W-1:0];
  assign q_data.last   = smp_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_shift <= SHIFT_RESET;
    end else if (cfg_valid) begin
      sample_shift <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (s_tready) begin
      smp_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      smp      <= shifted[SAMPLE_W-1:0];
      smp_last <= s_tlast;
    end
  end

endmodule

FILE: src/rlm_queue.sv
// short queue between front and back end
// depends on rlm_pkg
module rlm_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  rlm_pkg::q_entry_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rlm_pkg::q_entry_t out_data
);
  import rlm_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  q_entry_t          entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] fill;
  logic              push;
  logic              pop;

  assign in_ready  = fill != CNT_QW'(QUEUE_DEPTH);
  assign out_valid = fill != '0;
  assign out_data  = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_data;
    end
  end

endmodule

FILE: src/rlm_divlog.sv
// mean and level unit: restoring divide, normalize, squaring log2, scale
// depends on rlm_pkg
module rlm_divlog (
  input  logic             clk,
  input  logic             rst,
  input  rlm_pkg::dl_req_t req,
  output rlm_pkg::dl_rsp_t rsp
);
  import rlm_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_DIV   = 8'b0000_0010,
    ST_CHECK = 8'b0000_0100,
    ST_NORM  = 8'b0000_1000,
    ST_SQMUL = 8'b0001_0000,
    ST_SQCHK = 8'b0010_0000,
    ST_SCMUL = 8'b0100_0000,
    ST_SCFIN = 8'b1000_0000
  } dl_state_t;

  dl_state_t                 state;
  logic [CNT_W-1:0]          cnt;
  logic [SUM_W-1:0]          quot;
  logic [COUNT_W-1:0]        rem;
  logic [COUNT_W-1:0]        divisor;
  logic [MEAN_W-1:0]         x;
  logic [EXP_W-1:0]          e;
  logic [FRAC_W-1:0]         frac;
  logic [PROD_W-1:0]         prod;
  logic                      done;
  logic signed [LEVEL_W-1:0] level;

  logic [COUNT_W:0]          rem_sh;
  logic                      q_bit;
  logic [MEAN_W:0]           sq_top;
  logic [L2_W-1:0]           a;
  logic [PROD_W:0]           rounded;
  logic [MAG_W-1:0]          mag;

  // one quotient bit a cycle
  assign rem_sh = {rem, quot[SUM_W-1]};
  assign q_bit  = rem_sh >= {1'b0, divisor};
  // square of q1.30, back to q2.30
  assign sq_top = prod[PROD_W-1:MEAN_W-1];
  assign a      = LOG_SPAN - {e, frac};
  assign rounded = {1'b0, prod} + ((PROD_W + 1)'(1) << (SCALE_SHIFT - 1));
  assign mag    = rounded[SCALE_SHIFT +: MAG_W];

  assign rsp.busy  = state != ST_IDLE;
  assign rsp.done  = done;
  assign rsp.level = level;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (req.start) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (cnt == '0) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (quot == '0) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end else begin
            state <= ST_NORM;
          end
        end
        ST_NORM: begin
          if (x[MEAN_W-1]) begin
            state <= ST_SQMUL;
          end
        end
        ST_SQMUL: state <= ST_SQCHK;
        ST_SQCHK: begin
          state <= (cnt == '0) ? ST_SCMUL : ST_SQMUL;
        end
        ST_SCMUL: state <= ST_SCFIN;
        ST_SCFIN: begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        quot    <= req.dividend;
        divisor <= req.divisor;
        rem     <= '0;
        cnt     <= CNT_W'(SUM_W - 1);
      end
      ST_DIV: begin
        rem  <= q_bit ? COUNT_W'(rem_sh - {1'b0, divisor}) : rem_sh[COUNT_W-1:0];
        quot <= {quot[SUM_W-2:0], q_bit};
        cnt  <= cnt - 1'b1;
      end
      ST_CHECK: begin
        level <= SILENT_LEVEL;
        x     <= (quot > SUM_W'(MEAN_MAX)) ? MEAN_MAX : quot[MEAN_W-1:0];
        e     <= E_MAX;
        frac  <= '0;
        cnt   <= CNT_W'(FRAC_W - 1);
      end
      ST_NORM: begin
        if (!x[MEAN_W-1]) begin
          x <= {x[MEAN_W-2:0], 1'b0};
          e <= e - 1'b1;
        end
      end
      ST_SQMUL: begin
        prod <= PROD_W'(x) * PROD_W'(x);
      end
      ST_SQCHK: begin
        x    <= sq_top[MEAN_W] ? sq_top[MEAN_W:1] : sq_top[MEAN_W-1:0];
        frac <= {frac[FRAC_W-2:0], sq_top[MEAN_W]};
        cnt  <= cnt - 1'b1;
      end
      ST_SCMUL: begin
        prod <= PROD_W'(a) * PROD_W'(K_Q16);
      end
      ST_SCFIN: begin
        level <= -$signed({1'b0, mag});
      end
      default: ;
    endcase
  end

endmodule

FILE: src/rlm_back.sv
// back end: chunk accumulation, level hold, output register
// depends on rlm_pkg; drives rlm_divlog through a request struct
module rlm_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  rlm_pkg::q_entry_t           q_data,
  output rlm_pkg::dl_req_t            dl_req,
  input  rlm_pkg::dl_rsp_t            dl_rsp,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [31:0]                 m_tdata,
  output logic                        m_tlast,
  output logic                        m_tuser
);
  import rlm_pkg::*;

  typedef enum logic [2:0] {
    ST_RUN  = 3'b001,
    ST_CALC = 3'b010,
    ST_EMIT = 3'b100
  } back_state_t;

  back_state_t               state;
  logic [SUM_W-1:0]          square_sum;
  logic [COUNT_W-1:0]        sample_count;
  logic                      overflow_seen;
  logic signed [LEVEL_W-1:0] held_level;
  logic [SAMPLE_W-1:0]       pend_sample;
  logic                      pend_ovf;

  logic                      out_valid;
  logic [SAMPLE_W-1:0]       out_sample;
  logic                      out_last;
  logic [LEVEL_W-1:0]        out_level;
  logic                      out_ovf;

  logic                      out_free;
  logic                      pop;
  logic                      full;
  logic [SUM_W-1:0]          sum_next;
  logic [COUNT_W-1:0]        count_next;
  logic                      ovf_next;
  logic                      emit;

  assign out_free   = !out_valid || m_tready;
  assign q_ready    = (state == ST_RUN) && out_free;
  assign pop        = q_valid && q_ready;
  assign full       = sample_count == COUNT_W'(MAX_CHUNK);
  assign sum_next   = full ? square_sum : square_sum + SUM_W'(q_data.square);
  assign count_next = full ? sample_count : sample_count + 1'b1;
  assign ovf_next   = overflow_seen || full;
  assign emit       = (state == ST_EMIT) && out_free;

  assign dl_req.start    = pop && q_data.last;
  assign dl_req.dividend = sum_next;
  assign dl_req.divisor  = count_next;

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_level, out_sample};
  assign m_tlast  = out_last;
  assign m_tuser  = out_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_RUN;
      square_sum    <= '0;
      sample_count  <= '0;
      overflow_seen <= 1'b0;
      held_level    <= SILENT_LEVEL;
      out_valid     <= 1'b0;
    end else begin
      if ((pop && !q_data.last) || emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_RUN: begin
          if (pop) begin
            if (q_data.last) begin
              square_sum    <= '0;
              sample_count  <= '0;
              overflow_seen <= 1'b0;
              state         <= ST_CALC;
            end else begin
              square_sum    <= sum_next;
              sample_count  <= count_next;
              overflow_seen <= ovf_next;
            end
          end
        end
        ST_CALC: begin
          if (dl_rsp.done) begin
            held_level <= dl_rsp.level;
            state      <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            state <= ST_RUN;
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop && q_data.last) begin
      pend_sample <= q_data.sample;
      pend_ovf    <= ovf_next;
    end
    if (pop && !q_data.last) begin
      out_sample <= q_data.sample;
      out_last   <= 1'b0;
      out_level  <= held_level;
      out_ovf    <= ovf_next;
    end else if (emit) begin
      out_sample <= pend_sample;
      out_last   <= 1'b1;
      out_level  <= held_level;
      out_ovf    <= pend_ovf;
    end
  end

endmodule
